// ===== rtl/rlmp_pkg.sv =====
package rlmp_pkg;

	localparam int unsigned FuncW    = 3;
	localparam int unsigned CoordW   = 3;
	localparam int unsigned LevelW   = 8;
	localparam int unsigned ToneW    = 16;
	localparam int unsigned Rows     = 8;
	localparam int unsigned PixAddrW = 2 * CoordW;
	localparam int unsigned Pixels   = 1 << PixAddrW;
	localparam int unsigned PixelW   = 3 * LevelW;
	localparam int unsigned InDataW  = 80;
	localparam int unsigned OutDataW = 80;
	localparam int unsigned AddrW    = 3;
	localparam int unsigned ApbW     = 32;

	localparam logic [FuncW-1:0] FUNC_TICK      = 3'd0;
	localparam logic [FuncW-1:0] FUNC_SET_PIX   = 3'd1;
	localparam logic [FuncW-1:0] FUNC_CLR_PIX   = 3'd2;
	localparam logic [FuncW-1:0] FUNC_RD_PIX    = 3'd3;
	localparam logic [FuncW-1:0] FUNC_CLR_FRAME = 3'd4;
	localparam logic [FuncW-1:0] FUNC_TONE      = 3'd5;
	localparam logic [FuncW-1:0] FUNC_AUX       = 3'd6;

	localparam logic [LevelW-1:0] LEVELS_RESET = 8'd15;
	localparam logic [CoordW-1:0] LAST_COLUMN  = 3'd7;
	localparam logic [CoordW-1:0] LAST_ROW     = 3'd7;

	// controller to datapath commands
	typedef struct packed {
		logic              take;
		logic              rd_issue;
		logic [CoordW-1:0] rd_row;
		logic              out_load;
	} rlmp_cmd_t;

endpackage

// ===== rtl/rlmp_ram.sv =====
module rlmp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rlmp_ctrl.sv =====
module rlmp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic [rlmp_pkg::FuncW-1:0]    in_func,
	input  logic                          m_tready,
	output logic                          s_tready,
	output logic                          m_tvalid,
	output rlmp_pkg::rlmp_cmd_t           cmd
);
	import rlmp_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]        state_q;
	logic [CoordW-1:0] cnt_q;
	logic              single_q;
	logic              valid_q;
	logic              last_rd;
	logic              out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = valid_q;
	assign out_free = !valid_q || m_tready;
	assign last_rd  = single_q || (cnt_q == LAST_ROW);

	always_comb begin
		cmd          = '0;
		cmd.take     = (state_q == ST_IDLE) && s_tvalid;
		cmd.rd_issue = (state_q == ST_READ);
		cmd.rd_row   = cnt_q;
		cmd.out_load = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			single_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cnt_q    <= '0;
						single_q <= (in_func == FUNC_RD_PIX);
						if (in_func == FUNC_TICK || in_func == FUNC_RD_PIX) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_rd) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rlmp_dp.sv =====
module rlmp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rlmp_pkg::rlmp_cmd_t             cmd,
	input  logic [rlmp_pkg::InDataW-1:0]    in_data,
	input  logic                            cfg_we,
	input  logic [rlmp_pkg::LevelW-1:0]     cfg_wdata,
	output logic [rlmp_pkg::LevelW-1:0]     levels,
	output logic [rlmp_pkg::OutDataW-1:0]   out_data
);
	import rlmp_pkg::*;

	// input fields
	logic [FuncW-1:0]  i_func;
	logic [CoordW-1:0] i_x;
	logic [CoordW-1:0] i_y;
	logic [LevelW-1:0] i_red;
	logic [LevelW-1:0] i_green;
	logic [LevelW-1:0] i_blue;
	logic [ToneW-1:0]  i_period;
	logic [ToneW-1:0]  i_dur;
	logic [LevelW-1:0] i_aux;

	assign i_func   = in_data[2:0];
	assign i_x      = in_data[5:3];
	assign i_y      = in_data[8:6];
	assign i_red    = in_data[16:9];
	assign i_green  = in_data[24:17];
	assign i_blue   = in_data[32:25];
	assign i_period = in_data[48:33];
	assign i_dur    = in_data[64:49];
	assign i_aux    = in_data[72:65];

	logic [LevelW-1:0]   levels_q;
	logic [LevelW-1:0]   phase_q;
	logic [CoordW-1:0]   column_q;
	logic [ToneW-1:0]    tone_left_q;
	logic                sound_q;
	logic [ToneW-1:0]    tone_cmp_q;
	logic [LevelW-1:0]   aux_q;
	logic [Pixels-1:0]   pix_vld_q;
	logic [FuncW-1:0]    func_q;
	logic [CoordW-1:0]   x_q;
	logic [CoordW-1:0]   y_q;
	logic                frame_q;
	logic [Rows-1:0]     rmask_q;
	logic [Rows-1:0]     gmask_q;
	logic [Rows-1:0]     bmask_q;
	logic [LevelW-1:0]   rd_red_q;
	logic [LevelW-1:0]   rd_green_q;
	logic [LevelW-1:0]   rd_blue_q;
	logic [OutDataW-1:0] out_q;

	logic                rd_s1;
	logic [CoordW-1:0]   row_s1;
	logic                vld_s1;

	logic [LevelW-1:0]   next_phase;
	logic                wrap;
	logic [PixAddrW-1:0] wr_addr;
	logic [PixAddrW-1:0] rd_addr;
	logic [PixelW-1:0]   ram_rdata;
	logic [PixelW-1:0]   pix;
	logic                ram_we;
	logic                is_tick;
	logic [LevelW-1:0]   aux_out;

	assign levels     = levels_q;
	assign out_data   = out_q;
	assign next_phase = phase_q + 1'b1;
	assign wrap       = (next_phase >= levels_q);
	assign wr_addr    = {i_x, i_y};
	assign ram_we     = cmd.take && (i_func == FUNC_SET_PIX);
	assign is_tick    = (func_q == FUNC_TICK);
	assign rd_addr    = is_tick ? {column_q, cmd.rd_row} : {x_q, y_q};
	// pixel that was never written, or was cleared, reads as zero
	assign pix        = vld_s1 ? ram_rdata : '0;
	assign aux_out    = (is_tick && phase_q == '0 && column_q == '0) ? aux_q : '0;

	// one word per pixel: red, green, blue from the top
	rlmp_ram #(
		.WIDTH(PixelW),
		.DEPTH(Pixels)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata({i_red, i_green, i_blue}),
		.re   (cmd.rd_issue),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q    <= LEVELS_RESET;
			phase_q     <= '0;
			column_q    <= '0;
			tone_left_q <= '0;
			sound_q     <= 1'b0;
			tone_cmp_q  <= '0;
			aux_q       <= '0;
			pix_vld_q   <= '0;
			rd_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				levels_q <= cfg_wdata;
			end
			rd_s1 <= cmd.rd_issue;
			if (cmd.take) begin
				case (i_func)
					FUNC_TICK: begin
						if (wrap) begin
							phase_q  <= '0;
							column_q <= (column_q >= LAST_COLUMN) ? '0 : column_q + 1'b1;
							if (tone_left_q != '0) begin
								tone_left_q <= tone_left_q - 1'b1;
								if (tone_left_q == ToneW'(1)) begin
									sound_q <= 1'b0;
								end
							end
						end else begin
							phase_q <= next_phase;
						end
					end
					FUNC_SET_PIX:   pix_vld_q[wr_addr] <= 1'b1;
					FUNC_CLR_PIX:   pix_vld_q[wr_addr] <= 1'b0;
					FUNC_CLR_FRAME: pix_vld_q <= '0;
					FUNC_TONE: begin
						tone_cmp_q  <= i_period;
						sound_q     <= 1'b1;
						tone_left_q <= i_dur;
					end
					FUNC_AUX:       aux_q <= i_aux;
					default: ;
				endcase
			end
		end
	end

	// per-item scratch and result registers
	always_ff @(posedge clk) begin
		row_s1 <= cmd.rd_row;
		vld_s1 <= pix_vld_q[rd_addr];
		if (cmd.take) begin
			func_q     <= i_func;
			x_q        <= i_x;
			y_q        <= i_y;
			frame_q    <= (i_func == FUNC_TICK) && wrap && (column_q >= LAST_COLUMN);
			rmask_q    <= '0;
			gmask_q    <= '0;
			bmask_q    <= '0;
			rd_red_q   <= '0;
			rd_green_q <= '0;
			rd_blue_q  <= '0;
		end
		if (rd_s1) begin
			if (is_tick) begin
				rmask_q[row_s1] <= (pix[23:16] > phase_q);
				gmask_q[row_s1] <= (pix[15:8] > phase_q);
				bmask_q[row_s1] <= (pix[7:0] > phase_q);
			end else begin
				rd_red_q   <= pix[23:16];
				rd_green_q <= pix[15:8];
				rd_blue_q  <= pix[7:0];
			end
		end
		if (cmd.out_load) begin
			out_q <= {3'b000, rd_blue_q, rd_green_q, rd_red_q, tone_cmp_q, sound_q, frame_q,
				column_q, aux_out, bmask_q, gmask_q, rmask_q};
		end
	end

endmodule

// ===== rtl/rgb_led_matrix_pwm_scanner.sv =====
// Scanner for an 8x8 RGB LED matrix with 8-bit levels per color. Each input
// beat carries one operation (tick, set/clear/read pixel, clear frame, start
// tone, set aux LEDs) and yields exactly one result beat. A tick steps the
// PWM phase; when it reaches brightness_levels (APB register at byte 0,
// reset 15) the phase wraps, the column advances (frame_pulse on the wrap
// from column 7) and a running tone counts down. The tick result carries the
// red/green/blue row masks of the active column, bit y set where the level
// exceeds the phase, plus the aux byte at phase 0 of column 0. The frame is
// held in a 64-word pixel RAM (24 bits per pixel) with a valid flop per
// pixel, so reset and clear frame take effect at once with no clearing pass.
// One item is processed at a time: a tick makes 8 RAM reads after acceptance,
// one per row, then a drain step and the result load; a read pixel makes one
// read, any other operation goes straight to the load. The result sits in an
// output register, so a new beat is taken while the previous result waits.
// brightness_levels must only be written while the block is idle.
module rgb_led_matrix_pwm_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// func[2:0] x[5:3] y[8:6] red[16:9] green[24:17] blue[32:25]
	// tone_period[48:33] duration[64:49] aux_leds[72:65], zero fill above
	input  logic [rlmp_pkg::InDataW-1:0]  s_tdata,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// red_mask[7:0] green_mask[15:8] blue_mask[23:16] aux_byte[31:24]
	// active_column[34:32] frame_pulse[35] sound_on[36] tone_out[52:37]
	// read_red[60:53] read_green[68:61] read_blue[76:69], zero fill above
	output logic [rlmp_pkg::OutDataW-1:0] m_tdata,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rlmp_pkg::AddrW-1:0]    paddr,
	input  logic [rlmp_pkg::ApbW-1:0]     pwdata,
	output logic [rlmp_pkg::ApbW-1:0]     prdata,
	output logic                          pready
);
	import rlmp_pkg::*;

	rlmp_cmd_t         cmd;
	logic              cfg_hit;
	logic              cfg_we;
	logic [LevelW-1:0] levels;

	// only register 0 exists; word index is paddr[2]
	assign cfg_hit = (paddr[AddrW-1] == 1'b0);
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? {{(ApbW-LevelW){1'b0}}, levels} : '0;

	// sequencing: accept, row reads, result load
	rlmp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.in_func (s_tdata[FuncW-1:0]),
		.m_tready(m_tready),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.cmd     (cmd)
	);

	// scan state, tone state, pixel RAM and result register
	rlmp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(pwdata[LevelW-1:0]),
		.levels   (levels),
		.out_data (m_tdata)
	);

endmodule
